### rtl/core/ist_pkg.sv
// Shared types and codes for the indexed shift table.
// Holds the command and status codes and the cell control struct; no dependencies.
`default_nettype none

package ist_pkg;

    // Command codes carried by an input request.
    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_POP    = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;
    localparam logic [2:0] CMD_FIND   = 3'd5;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;  // open a slot at the position and load the write data
        logic del;  // close the slot at the position by pulling from above
    } cell_op_t;

endpackage

`default_nettype wire

### rtl/core/indexed_shift_table.sv
// Top level of the indexed shift table: command sequencer and chain of cells.
// Depends on ist_pkg and ist_cell.
//
// A packed table of DEPTH signed entries with a fill count, held in a row of cells that
// shift up on insert and down on pop, delete or remove. One request is in work at a time
// and the next is accepted once its result has been taken. Read, insert, pop, delete and
// unknown commands finish in the cycle they are accepted, with the result registered in
// the next cycle. Remove and find walk a scan pointer over the table, one entry per cycle,
// and finish once the pointer reaches the fill count; a find also finishes at its first
// match. A removed entry closes its gap in the same cycle that tests it and the pointer
// stays put, so the next entry moves under it. The entry store has no reset; only the
// state, the fill count and the result valid flag are cleared.
`default_nettype none

module indexed_shift_table
    import ist_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_command,
    input  wire logic [5:0]         s_index,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_read_value,
    output logic                    m_found,
    output logic [4:0]              m_position,
    output logic [5:0]              m_fill_count,
    output logic [1:0]              m_status
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [WIDTH-1:0]     key_reg, key_next;
    logic                 m_valid_reg, m_valid_next;
    logic signed [31:0]   rd_reg, rd_next;
    logic                 found_reg, found_next;
    logic [4:0]           pos_reg, pos_next;
    logic [5:0]           fill_reg, fill_next;
    logic [1:0]           status_reg, status_next;

    cell_op_t             op;
    logic [AW-1:0]        cell_pos;
    logic [WIDTH-1:0]     wdata;
    logic [WIDTH-1:0]     entry_arr [DEPTH];
    logic [DEPTH-1:0]     match;
    logic                 accept;
    logic [CMPW-1:0]      idx_ext;
    logic [CMPW-1:0]      cnt_ext;
    logic [AW-1:0]        idx_a;
    logic [AW-1:0]        scan_a;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;
    assign wdata   = WIDTH'($unsigned(s_value));
    assign idx_ext = CMPW'(s_index);
    assign cnt_ext = CMPW'(count_reg);
    assign idx_a   = AW'(s_index);
    assign scan_a  = scan_reg[AW-1:0];

    // Chain of cells; each one sees its neighbors and the broadcast control.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] left_in;
        logic [WIDTH-1:0] right_in;
        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_inner_l
            assign left_in = entry_arr[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_inner_r
            assign right_in = entry_arr[i+1];
        end
        ist_cell #(
            .IDX   (i),
            .DEPTH (DEPTH),
            .WIDTH (WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .pos        (cell_pos),
            .left_data  (left_in),
            .right_data (right_in),
            .wdata      (wdata),
            .key        (key_reg),
            .entry      (entry_arr[i]),
            .match      (match[i])
        );
    end

    // Sequencer: read, insert, pop and delete finish at accept, scan loop for remove and find.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        m_valid_next = m_valid_reg;
        rd_next      = rd_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        status_next  = status_reg;
        op           = '0;
        cell_pos     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    rd_next     = '0;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    status_next = ST_OK;
                    case (s_command)
                        CMD_READ: begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else if (idx_ext >= cnt_ext) begin
                                status_next = ST_RANGE;
                            end else begin
                                rd_next = 32'($signed(entry_arr[idx_a]));
                            end
                        end
                        CMD_INSERT: begin
                            m_valid_next = 1'b1;
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else if (idx_ext > cnt_ext) begin
                                status_next = ST_RANGE;
                            end else begin
                                op.ins     = 1'b1;
                                cell_pos   = idx_a;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rd_next    = 32'($signed(entry_arr[0]));
                                op.del     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else if (idx_ext >= cnt_ext) begin
                                status_next = ST_RANGE;
                            end else begin
                                op.del     = 1'b1;
                                cell_pos   = idx_a;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_REMOVE, CMD_FIND: begin
                            cmd_next   = s_command;
                            key_next   = wdata;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                    fill_next = 6'(count_next);
                end
            end
            S_SCAN: begin
                if (scan_reg >= count_reg) begin
                    // Walked off the end of the table.
                    m_valid_next = 1'b1;
                    fill_next    = 6'(count_reg);
                    state_next   = S_IDLE;
                end else if (match[scan_a]) begin
                    if (cmd_reg == CMD_FIND) begin
                        m_valid_next = 1'b1;
                        found_next   = 1'b1;
                        pos_next     = 5'(scan_reg);
                        fill_next    = 6'(count_reg);
                        state_next   = S_IDLE;
                    end else begin
                        // Close the gap; the next entry moves under the pointer.
                        op.del     = 1'b1;
                        cell_pos   = scan_a;
                        count_next = count_reg - 1'b1;
                    end
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, fill count and the registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        scan_reg   <= scan_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        fill_reg   <= fill_next;
        status_reg <= status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = rd_reg;
    assign m_found      = found_reg;
    assign m_position   = pos_reg;
    assign m_fill_count = fill_reg;
    assign m_status     = status_reg;

endmodule

`default_nettype wire

### rtl/core/ist_cell.sv
// One storage cell of the indexed shift table chain.
// Depends on ist_pkg for the cell control struct.
`default_nettype none

module ist_cell
    import ist_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire cell_op_t                   op,
    input  wire logic [$clog2(DEPTH)-1:0]   pos,
    input  wire logic [WIDTH-1:0]           left_data,
    input  wire logic [WIDTH-1:0]           right_data,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [WIDTH-1:0]           key,
    output logic      [WIDTH-1:0]           entry,
    output logic                            match
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] entry_next;
    logic             at_pos;
    logic             above_pos;

    assign at_pos    = (MY_IDX == pos);
    assign above_pos = (MY_IDX > pos);

    // An insert loads the new value here or takes the neighbor below;
    // a delete pulls the neighbor above down into this cell.
    always_comb begin
        entry_next = entry_reg;
        if (op.ins && at_pos) begin
            entry_next = wdata;
        end else if (op.ins && above_pos) begin
            entry_next = left_data;
        end else if (op.del && (at_pos || above_pos)) begin
            entry_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == key);

endmodule

`default_nettype wire
